@@ design/tlc_pkg.sv @@
// Shared constants, types and packing for the two-way LRU cache lookup core.
package tlc_pkg;

   localparam int NUM_SETS   = 64;
   localparam int LINE_BYTES = 32;
   localparam int ADDR_BITS  = 32;

   localparam int OFF_W   = $clog2(LINE_BYTES);
   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int BLOCK_W = ADDR_BITS - OFF_W;
   localparam int TAG_W   = BLOCK_W - SET_W;
   localparam int CNT_W   = 32;

   // Result item, fields from the lowest bit up.
   localparam int RSP_BITS  = OFF_W + BLOCK_W + SET_W + 1 + TAG_W + 1 + 1 + TAG_W
                              + CNT_W + CNT_W;
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;
   localparam int RSP_W     = RSP_BYTES * 8;
   localparam int REQ_W     = ((ADDR_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic [CNT_W-1:0]   hit_count;
      logic [CNT_W-1:0]   reference_count;
      logic [TAG_W-1:0]   evicted_tag;
      logic               replaced_valid;
      logic               is_miss;
      logic [TAG_W-1:0]   line_tag;
      logic               way_used;
      logic [SET_W-1:0]   set_index;
      logic [BLOCK_W-1:0] block_number;
      logic [OFF_W-1:0]   byte_offset;
   } rsp_type;

   // One row of the tag memory: both tags and the set's last used way.
   typedef struct packed {
      logic             lru;
      logic [TAG_W-1:0] tag1;
      logic [TAG_W-1:0] tag0;
   } row_type;

   typedef struct packed {
      logic capture;   // take the input item and read its set
      logic commit;    // resolve, write back and load the result
   } cmd_type;

   typedef struct packed {
      logic out_free;  // result register empty or being taken
   } stat_type;

endpackage

@@ design/two_way_lru_cache_lookup_core.sv @@
// Top level of the two-way set-associative LRU cache lookup core.
//
//   group   direction  tdata fields (lowest bit up)                         tuser/tlast
//   req_    in         address                                                none
//   rsp_    out        byte_offset, block_number, set_index, way_used,        none
//                      line_tag, is_miss, replaced_valid, evicted_tag,
//                      reference_count, hit_count
//
// For each item the core first accepts it and reads its set's tag row, then compares,
// writes the row back and loads the result register (single-port tag memory).
// The next item is accepted while a result waits; the lookup holds while it still waits.
// Reset clears the valid bits, counters and result valid flag; no clearing pass is run.
module two_way_lru_cache_lookup_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tlc_pkg::REQ_W-1:0]  req_tdata,   // address
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // byte_offset, block_number, set_index, way_used, line_tag, is_miss,
   // replaced_valid, evicted_tag, reference_count, hit_count, zero pad
   output logic [tlc_pkg::RSP_W-1:0]  rsp_tdata
);

   tlc_pkg::cmd_type  cmd;
   tlc_pkg::stat_type stat;

   tlc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tlc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ design/tlc_ctrl.sv @@
// Controller: sequences accept, lookup and result hand-off for each item.
module tlc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  tlc_pkg::stat_type  stat,
   output tlc_pkg::cmd_type   cmd
);

   localparam logic ST_IDLE    = 1'b0;
   localparam logic ST_RESOLVE = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_tready  = (state_ff == ST_IDLE);
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.commit  = (state_ff == ST_RESOLVE) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            // hold until the result register can take the item
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit in the same cycle");

   a_capture_then_resolve: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_RESOLVE) && !req_tready)
      else $error("accepted item not followed by lookup");

endmodule

@@ design/tlc_datapath.sv @@
// Datapath: tag memory, valid bits, counters, lookup logic and result register.
module tlc_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  tlc_pkg::cmd_type           cmd,
   output tlc_pkg::stat_type          stat,
   input  logic [tlc_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tlc_pkg::RSP_W-1:0]  rsp_tdata
);

   tlc_pkg::row_type tag_mem [tlc_pkg::NUM_SETS];
   tlc_pkg::row_type rd_row_ff;

   logic [tlc_pkg::ADDR_BITS-1:0] addr_ff;
   logic [tlc_pkg::NUM_SETS-1:0]  way0_valid_ff;
   logic [tlc_pkg::NUM_SETS-1:0]  way1_valid_ff;
   logic [tlc_pkg::CNT_W-1:0]     ref_count_ff;
   logic [tlc_pkg::CNT_W-1:0]     hit_count_ff;
   logic [tlc_pkg::CNT_W-1:0]     ref_count_in;
   logic [tlc_pkg::CNT_W-1:0]     hit_count_in;
   logic                          rsp_valid_ff;
   tlc_pkg::rsp_type              rsp_ff;
   tlc_pkg::rsp_type              rsp_in;
   tlc_pkg::row_type              wr_row;

   logic [tlc_pkg::SET_W-1:0]     req_set;
   logic [tlc_pkg::OFF_W-1:0]     cur_off;
   logic [tlc_pkg::BLOCK_W-1:0]   cur_block;
   logic [tlc_pkg::SET_W-1:0]     cur_set;
   logic [tlc_pkg::TAG_W-1:0]     cur_tag;
   logic                          v0;
   logic                          v1;
   logic                          way;
   logic                          miss;
   logic                          repl;
   logic [tlc_pkg::TAG_W-1:0]     victim;

   assign req_set   = req_tdata[tlc_pkg::OFF_W +: tlc_pkg::SET_W];
   assign cur_off   = addr_ff[tlc_pkg::OFF_W-1:0];
   assign cur_block = addr_ff[tlc_pkg::ADDR_BITS-1:tlc_pkg::OFF_W];
   assign cur_set   = cur_block[tlc_pkg::SET_W-1:0];
   assign cur_tag   = cur_block[tlc_pkg::BLOCK_W-1:tlc_pkg::SET_W];
   assign v0        = way0_valid_ff[cur_set];
   assign v1        = way1_valid_ff[cur_set];

   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   // Read the set on accept; the previous item's write-back is already in.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff   <= req_tdata[tlc_pkg::ADDR_BITS-1:0];
         rd_row_ff <= tag_mem[req_set];
      end
   end

   always_comb begin
      wr_row = rd_row_ff;
      repl   = 1'b0;
      victim = '0;
      priority if (!v0) begin
         way         = 1'b0;
         miss        = 1'b1;
         wr_row.tag0 = cur_tag;
      end else if (rd_row_ff.tag0 == cur_tag) begin
         way  = 1'b0;
         miss = 1'b0;
      end else if (!v1) begin
         way         = 1'b1;
         miss        = 1'b1;
         wr_row.tag1 = cur_tag;
      end else if (rd_row_ff.tag1 == cur_tag) begin
         way  = 1'b1;
         miss = 1'b0;
      end else if (rd_row_ff.lru) begin
         way         = 1'b0;
         miss        = 1'b1;
         repl        = 1'b1;
         victim      = rd_row_ff.tag0;
         wr_row.tag0 = cur_tag;
      end else begin
         way         = 1'b1;
         miss        = 1'b1;
         repl        = 1'b1;
         victim      = rd_row_ff.tag1;
         wr_row.tag1 = cur_tag;
      end
      wr_row.lru = way;
   end

   assign ref_count_in = ref_count_ff + 1'b1;
   assign hit_count_in = miss ? hit_count_ff : hit_count_ff + 1'b1;

   always_comb begin
      rsp_in.byte_offset     = cur_off;
      rsp_in.block_number    = cur_block;
      rsp_in.set_index       = cur_set;
      rsp_in.way_used        = way;
      rsp_in.line_tag        = cur_tag;
      rsp_in.is_miss         = miss;
      rsp_in.replaced_valid  = repl;
      rsp_in.evicted_tag     = victim;
      rsp_in.reference_count = ref_count_in;
      rsp_in.hit_count       = hit_count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tag_mem[cur_set] <= wr_row;
         rsp_ff           <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         way0_valid_ff <= '0;
         way1_valid_ff <= '0;
         ref_count_ff  <= '0;
         hit_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.commit) begin
            if (way) way1_valid_ff[cur_set] <= 1'b1;
            else     way0_valid_ff[cur_set] <= 1'b1;
            ref_count_ff <= ref_count_in;
            hit_count_ff <= hit_count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tlc_pkg::RSP_W - tlc_pkg::RSP_BITS){1'b0}}, rsp_ff};

   a_commit_loads_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not load the result register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_hit_only_on_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !miss) |-> (way ? v1 : v0))
      else $error("hit reported on an invalid way");

   a_repl_needs_both: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && repl) |-> (v0 && v1 && miss))
      else $error("eviction without both ways valid");

endmodule
